// ===== sv/gcd_pkg.sv =====
// ============================================================================
// gcd_pkg: shared types, constants and microcode for the change dispenser
// Denomination and stock tables, stream packing widths and the control store.
// ============================================================================
package gcd_pkg;

    localparam int NUM_DENOMS   = 9;
    localparam int COUNT_BITS   = 8;
    localparam int MAX_SLOTS    = 16;
    localparam int SLOT_BITS    = 4;
    localparam int DENOM_BITS   = 10;
    localparam int DISP_BITS    = 8;
    localparam int AMOUNT_BITS  = 16;
    localparam int REM_BITS     = AMOUNT_BITS + 1;
    localparam int STATUS_BITS  = 2;
    localparam int STEP_BITS    = 2;

    // Reciprocal quotient: fit = (change * recip) >> RECIP_SHIFT.
    localparam int RECIP_BITS   = 27;
    localparam int RECIP_SHIFT  = 26;
    localparam int PROD_BITS    = AMOUNT_BITS + RECIP_BITS;
    localparam int PAY_BITS     = COUNT_BITS + DENOM_BITS;

    // Stream word layout, lowest field first, padded to whole bytes.
    localparam int S_DATA_BITS = 2 * AMOUNT_BITS + SLOT_BITS + COUNT_BITS;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = SLOT_BITS + DENOM_BITS + DISP_BITS + REM_BITS;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_DENOMS - 1);

    typedef logic [STEP_BITS-1:0] step_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_EXACT    = 2'd0,
        ST_SHORT    = 2'd1,
        ST_UNDERPAY = 2'd2,
        ST_LOAD_ACK = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_FETCH,
        OP_QUOT,
        OP_EMIT_SALE,
        OP_EMIT_LOAD
    } op_t;

    typedef enum logic [1:0] {
        CND_NEVER,
        CND_LOAD_MODE,
        CND_MORE_SLOTS
    } cond_t;

    // One control word: operation, jump condition, jump target, and whether
    // a failed jump returns to the fetch step instead of falling through.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  ret;
    } ucode_t;

    localparam step_t STEP_FETCH = 2'd0;
    localparam step_t STEP_QUOT  = 2'd1;
    localparam step_t STEP_EMIT  = 2'd2;
    localparam step_t STEP_LOAD  = 2'd3;

    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t w;
        case (pc)
            STEP_FETCH: w = '{op: OP_FETCH,     cond: CND_LOAD_MODE,  target: STEP_LOAD,
                              ret: 1'b0};
            STEP_QUOT:  w = '{op: OP_QUOT,      cond: CND_NEVER,      target: STEP_FETCH,
                              ret: 1'b0};
            STEP_EMIT:  w = '{op: OP_EMIT_SALE, cond: CND_MORE_SLOTS, target: STEP_QUOT,
                              ret: 1'b1};
            STEP_LOAD:  w = '{op: OP_EMIT_LOAD, cond: CND_NEVER,      target: STEP_FETCH,
                              ret: 1'b1};
            default:    w = '{op: OP_FETCH,     cond: CND_NEVER,      target: STEP_FETCH,
                              ret: 1'b1};
        endcase
        return w;
    endfunction

    // Face values in half units; slots past the drawer have none.
    function automatic logic [DENOM_BITS-1:0] denom_of(input logic [SLOT_BITS-1:0] s);
        logic [DENOM_BITS-1:0] d;
        case (s)
            4'd0:    d = 10'd1000;
            4'd1:    d = 10'd200;
            4'd2:    d = 10'd100;
            4'd3:    d = 10'd40;
            4'd4:    d = 10'd20;
            4'd5:    d = 10'd10;
            4'd6:    d = 10'd4;
            4'd7:    d = 10'd2;
            4'd8:    d = 10'd1;
            default: d = 10'd0;
        endcase
        return d;
    endfunction

    // Rounded-up 2^26 / face value. The rounding error stays below the face
    // value, so the scaled product floors to the exact quotient for every
    // 16-bit change.
    function automatic logic [RECIP_BITS-1:0] recip_of(input logic [SLOT_BITS-1:0] s);
        logic [RECIP_BITS-1:0] r;
        case (s)
            4'd0:    r = 27'd67109;
            4'd1:    r = 27'd335545;
            4'd2:    r = 27'd671089;
            4'd3:    r = 27'd1677722;
            4'd4:    r = 27'd3355444;
            4'd5:    r = 27'd6710887;
            4'd6:    r = 27'd16777216;
            4'd7:    r = 27'd33554432;
            4'd8:    r = 27'd67108864;
            default: r = 27'd0;
        endcase
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] reset_count_of(input int s);
        logic [COUNT_BITS-1:0] c;
        case (s)
            0:       c = COUNT_BITS'(3);
            1:       c = COUNT_BITS'(7);
            2:       c = COUNT_BITS'(12);
            3:       c = COUNT_BITS'(22);
            4:       c = COUNT_BITS'(15);
            5:       c = COUNT_BITS'(25);
            6:       c = COUNT_BITS'(15);
            7:       c = COUNT_BITS'(25);
            8:       c = COUNT_BITS'(20);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/greedy_change_dispenser_core.sv =====
// ============================================================================
// greedy_change_dispenser_core: cash-drawer change maker with limited stock
// Order: a sale loads its first output word at the emit step, after the
// fetch and quotient steps; a load acknowledge at the load step after fetch.
// Flow: a sale runs a fetch step, then a quotient and an emit step per slot,
// holding while the output stalls; a new item is taken only at the fetch step.
// Reset: the drawer returns to its opening stock, the output register empties
// and the sequencer waits at its fetch step.
// ============================================================================
module greedy_change_dispenser_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // price [15:0], paid [31:16], slot [35:32], count [43:36], zero pad above
    input  logic [gcd_pkg::S_TDATA_W-1:0] s_tdata,
    // mode [0]
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // slot_out [3:0], denomination [13:4], dispensed [21:14],
    // remainder [38:22], zero pad above
    output logic [gcd_pkg::M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [gcd_pkg::STATUS_BITS-1:0] m_tuser,
    output logic                        m_tlast
);
    import gcd_pkg::*;

    // The sequencer reads one control word per cycle from the control store.
    // The fetch step takes a word; a sale then spends two steps per slot.
    // The quotient step multiplies the change still owed by the slot's
    // reciprocal and caps the result at the slot's stock. The emit step
    // subtracts the pieces given, writes back the stock, loads the output
    // register and advances to the next slot.

    // Unpacked input fields.
    logic [AMOUNT_BITS-1:0] in_price;
    logic [AMOUNT_BITS-1:0] in_paid;
    logic [SLOT_BITS-1:0]   in_slot;
    logic [COUNT_BITS-1:0]  in_count;

    assign in_price = s_tdata[AMOUNT_BITS-1:0];
    assign in_paid  = s_tdata[2*AMOUNT_BITS-1:AMOUNT_BITS];
    assign in_slot  = s_tdata[2*AMOUNT_BITS+SLOT_BITS-1:2*AMOUNT_BITS];
    assign in_count = s_tdata[S_DATA_BITS-1:2*AMOUNT_BITS+SLOT_BITS];

    // Sequencer and datapath registers.
    step_t                   pc_reg, pc_next;
    logic [SLOT_BITS-1:0]    slot_reg, slot_next;
    logic signed [REM_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0]   give_reg, give_next;
    logic                    neg_reg, neg_next;
    logic [COUNT_BITS-1:0]   ld_count_reg, ld_count_next;

    // Drawer stock, one register per slot, read at the current slot only.
    logic [COUNT_BITS-1:0]   counts_reg [NUM_DENOMS];
    logic                    cnt_we;
    logic [SLOT_BITS-1:0]    cnt_wa;
    logic [COUNT_BITS-1:0]   cnt_wd;

    // Output register.
    logic                    m_valid_reg, m_valid_next;
    logic [SLOT_BITS-1:0]    o_slot_reg, o_slot_next;
    logic [DENOM_BITS-1:0]   o_denom_reg, o_denom_next;
    logic [DISP_BITS-1:0]    o_disp_reg, o_disp_next;
    logic signed [REM_BITS-1:0] o_rem_reg, o_rem_next;
    status_t                 o_status_reg, o_status_next;
    logic                    o_last_reg, o_last_next;

    // Decode and datapath signals.
    ucode_t                  uw;
    logic                    hold;
    logic                    jump;
    logic                    slot_in_drawer;
    logic [COUNT_BITS-1:0]   stock;
    logic [DENOM_BITS-1:0]   denom;
    logic [RECIP_BITS-1:0]   recip;
    logic [PROD_BITS-1:0]    prod;
    logic [AMOUNT_BITS-1:0]  fit;
    logic [COUNT_BITS-1:0]   give_q;
    logic [PAY_BITS-1:0]     pay;
    logic signed [REM_BITS-1:0] rem_after;
    logic                    out_busy;
    logic                    is_last_slot;

    assign uw             = ucode_rom(pc_reg);
    assign slot_in_drawer = (slot_reg < SLOT_BITS'(NUM_DENOMS));
    assign stock          = slot_in_drawer ? counts_reg[slot_reg] : '0;
    assign denom          = denom_of(slot_reg);
    assign recip          = recip_of(slot_reg);
    assign out_busy       = m_valid_reg && !m_tready;
    assign is_last_slot   = (slot_reg == LAST_SLOT);

    // Pieces that fit into the change still owed, capped at the stock. The
    // product is only meaningful while the change is not negative.
    assign prod   = PROD_BITS'(rem_reg[AMOUNT_BITS-1:0]) * PROD_BITS'(recip);
    assign fit    = prod[RECIP_SHIFT+AMOUNT_BITS-1:RECIP_SHIFT];
    assign give_q = (fit < AMOUNT_BITS'(stock)) ? fit[COUNT_BITS-1:0] : stock;

    // Value handed out at the emit step; it never exceeds the change owed.
    assign pay       = PAY_BITS'(give_reg) * PAY_BITS'(denom);
    assign rem_after = rem_reg - $signed({1'b0, pay[AMOUNT_BITS-1:0]});

    // Step counter: a stalled step holds, otherwise the word's condition
    // picks the jump target, the fetch step, or the next step.
    always_comb begin
        case (uw.op)
            OP_FETCH:     hold = !s_tvalid;
            OP_EMIT_SALE: hold = out_busy;
            OP_EMIT_LOAD: hold = out_busy;
            default:      hold = 1'b0;
        endcase
        case (uw.cond)
            CND_LOAD_MODE:  jump = s_tuser;
            CND_MORE_SLOTS: jump = !is_last_slot;
            default:        jump = 1'b0;
        endcase
        if (hold) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = uw.target;
        end else if (uw.ret) begin
            pc_next = STEP_FETCH;
        end else begin
            pc_next = pc_reg + step_t'(1);
        end
    end

    // Datapath driven by the control word.
    always_comb begin
        slot_next     = slot_reg;
        rem_next      = rem_reg;
        give_next     = give_reg;
        neg_next      = neg_reg;
        ld_count_next = ld_count_reg;
        cnt_we        = 1'b0;
        cnt_wa        = slot_reg;
        cnt_wd        = ld_count_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        o_slot_next   = o_slot_reg;
        o_denom_next  = o_denom_reg;
        o_disp_next   = o_disp_reg;
        o_rem_next    = o_rem_reg;
        o_status_next = o_status_reg;
        o_last_next   = o_last_reg;
        case (uw.op)
            OP_FETCH: begin
                if (!hold) begin
                    rem_next      = $signed({1'b0, in_paid}) - $signed({1'b0, in_price});
                    neg_next      = (in_paid < in_price);
                    slot_next     = s_tuser ? in_slot : '0;
                    ld_count_next = in_count;
                    give_next     = '0;
                end
            end
            OP_QUOT: begin
                // A negative change never takes anything.
                give_next = rem_reg[REM_BITS-1] ? '0 : give_q;
            end
            OP_EMIT_SALE: begin
                if (!hold) begin
                    cnt_we        = 1'b1;
                    cnt_wd        = stock - give_reg;
                    rem_next      = rem_after;
                    m_valid_next  = 1'b1;
                    o_slot_next   = slot_reg;
                    o_denom_next  = denom;
                    o_disp_next   = give_reg[DISP_BITS-1:0];
                    o_rem_next    = rem_after;
                    o_last_next   = is_last_slot;
                    if (!is_last_slot) begin
                        o_status_next = ST_EXACT;
                    end else if (neg_reg) begin
                        o_status_next = ST_UNDERPAY;
                    end else if (rem_after == '0) begin
                        o_status_next = ST_EXACT;
                    end else begin
                        o_status_next = ST_SHORT;
                    end
                    slot_next = slot_reg + SLOT_BITS'(1);
                end
            end
            OP_EMIT_LOAD: begin
                if (!hold) begin
                    // A slot beyond the drawer is acknowledged but not stored.
                    cnt_we        = slot_in_drawer;
                    cnt_wd        = ld_count_reg;
                    m_valid_next  = 1'b1;
                    o_slot_next   = slot_reg;
                    o_denom_next  = denom;
                    o_disp_next   = '0;
                    o_rem_next    = '0;
                    o_status_next = ST_LOAD_ACK;
                    o_last_next   = 1'b1;
                end
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // Control state and stock, returned by reset to their start values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= STEP_FETCH;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_DENOMS; i++) begin
                counts_reg[i] <= reset_count_of(i);
            end
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            if (cnt_we) begin
                counts_reg[cnt_wa] <= cnt_wd;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        slot_reg     <= slot_next;
        rem_reg      <= rem_next;
        give_reg     <= give_next;
        neg_reg      <= neg_next;
        ld_count_reg <= ld_count_next;
        o_slot_reg   <= o_slot_next;
        o_denom_reg  <= o_denom_next;
        o_disp_reg   <= o_disp_next;
        o_rem_reg    <= o_rem_next;
        o_status_reg <= o_status_next;
        o_last_reg   <= o_last_next;
    end

    // Ports. The input is taken only at the fetch step.
    assign s_tready = (pc_reg == STEP_FETCH);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({o_rem_reg, o_disp_reg, o_denom_reg, o_slot_reg});
    assign m_tuser  = o_status_reg;
    assign m_tlast  = o_last_reg;

    // Only the final word of an item carries an outcome.
    a_status_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !o_last_reg) |-> (o_status_reg == ST_EXACT))
        else $error("outcome status on a word that is not last");

    // Pieces handed out strictly lower the change still owed.
    a_rem_falls: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == OP_EMIT_SALE && give_reg != '0) |-> (rem_after < rem_reg))
        else $error("dispensed pieces did not lower the remainder");

    // The drawer never gives more pieces than it holds.
    a_give_in_stock: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == OP_EMIT_SALE) |-> (give_reg <= stock))
        else $error("dispensed count exceeds stock");

    // An underpaid sale dispenses nothing.
    a_underpaid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == OP_EMIT_SALE && neg_reg) |-> (give_reg == '0))
        else $error("pieces dispensed on an underpaid sale");

endmodule
